[rtl/apq_pkg.sv]
// Package for the aging priority queue: types, codes, widths and reset values.
// Used by apq_cfg_regs and aging_priority_queue_unit; depends on nothing.
package apq_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned IdW      = 16;
  localparam int unsigned PrioW    = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ClsW     = 2;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 5;

  localparam logic [PrioW-1:0] PrioMax = {PrioW{1'b1}};

  localparam logic [PrioW-1:0] EmergencyPrioRst = 16'd100;
  localparam logic [PrioW-1:0] LandingPrioRst   = 16'd50;
  localparam logic [PrioW-1:0] TakeoffPrioRst   = 16'd10;
  localparam logic [PrioW-1:0] AgingThreshRst   = 16'd5;
  localparam logic [PrioW-1:0] AgingStepRst     = 16'd5;

  typedef enum logic [OpW-1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic [ClsW-1:0] {
    CLS_LANDING   = 2'd0,
    CLS_EMERGENCY = 2'd1,
    CLS_TAKEOFF   = 2'd2
  } class_e;

  typedef enum logic [StatusW-1:0] {
    STS_INSERTED  = 3'd0,
    STS_FULL      = 3'd1,
    STS_EXTRACTED = 3'd2,
    STS_EMPTY     = 3'd3,
    STS_TICK_DONE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_EMERGENCY_PRIO = 3'd0,
    REG_LANDING_PRIO   = 3'd1,
    REG_TAKEOFF_PRIO   = 3'd2,
    REG_AGING_THRESH   = 3'd3,
    REG_AGING_STEP     = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_AGE
  } state_e;

  typedef struct packed {
    logic [PrioW-1:0] emergency_prio;
    logic [PrioW-1:0] landing_prio;
    logic [PrioW-1:0] takeoff_prio;
    logic [PrioW-1:0] aging_thresh;
    logic [PrioW-1:0] aging_step;
  } cfg_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [ClsW-1:0]  cls;
    logic [TimeW-1:0] arrival;
    logic [PrioW-1:0] prio;
  } entry_t;

  // Unknown class codes fall back to the takeoff priority.
  function automatic logic [PrioW-1:0] class_prio(cfg_t cfg, logic [ClsW-1:0] cls);
    logic [PrioW-1:0] prio;
    case (cls)
      CLS_LANDING:   prio = cfg.landing_prio;
      CLS_EMERGENCY: prio = cfg.emergency_prio;
      default:       prio = cfg.takeoff_prio;
    endcase
    return prio;
  endfunction

endpackage

[rtl/apq_cfg_regs.sv]
// APB-style configuration register file of the aging priority queue.
// Depends on apq_pkg for the register map, reset values and cfg_t.
module apq_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apq_pkg::CfgAddrW-1:0]  paddr,
  input  logic [apq_pkg::CfgDataW-1:0]  pwdata,
  output logic [apq_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output apq_pkg::cfg_t                 cfg_o
);

  apq_pkg::cfg_t    cfg_q, cfg_d;
  logic [2:0]       reg_idx;
  logic             wr_en;
  logic [apq_pkg::PrioW-1:0] wr_val;
  logic [apq_pkg::PrioW-1:0] rd_val;

  assign reg_idx = paddr[apq_pkg::CfgAddrW-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign wr_val  = pwdata[apq_pkg::PrioW-1:0];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        apq_pkg::REG_EMERGENCY_PRIO: cfg_d.emergency_prio = wr_val;
        apq_pkg::REG_LANDING_PRIO:   cfg_d.landing_prio   = wr_val;
        apq_pkg::REG_TAKEOFF_PRIO:   cfg_d.takeoff_prio   = wr_val;
        apq_pkg::REG_AGING_THRESH:   cfg_d.aging_thresh   = wr_val;
        apq_pkg::REG_AGING_STEP:     cfg_d.aging_step     = wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      apq_pkg::REG_EMERGENCY_PRIO: rd_val = cfg_q.emergency_prio;
      apq_pkg::REG_LANDING_PRIO:   rd_val = cfg_q.landing_prio;
      apq_pkg::REG_TAKEOFF_PRIO:   rd_val = cfg_q.takeoff_prio;
      apq_pkg::REG_AGING_THRESH:   rd_val = cfg_q.aging_thresh;
      apq_pkg::REG_AGING_STEP:     rd_val = cfg_q.aging_step;
      default:                     rd_val = '0;
    endcase
  end

  assign prdata = {{(apq_pkg::CfgDataW - apq_pkg::PrioW){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.emergency_prio <= apq_pkg::EmergencyPrioRst;
      cfg_q.landing_prio   <= apq_pkg::LandingPrioRst;
      cfg_q.takeoff_prio   <= apq_pkg::TakeoffPrioRst;
      cfg_q.aging_thresh   <= apq_pkg::AgingThreshRst;
      cfg_q.aging_step     <= apq_pkg::AgingStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/aging_priority_queue_unit.sv]
// Top level of the aging priority queue: entry memory, sequencer and result register.
// Depends on apq_pkg and apq_cfg_regs.
//
//   channel   handshake                  payload
//   command   start / busy               operation_i, request_class_i, request_id_i
//   result    done_o (one-cycle strobe)  status_o, granted_id_o, occupancy_o
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Insert, and extract or tick on an empty queue: result in the next cycle, busy stays low.
// Tick, and extract on a non-empty queue, raise busy until the result; busy drops in the
// result's cycle. Entries stream through the one read port. A tick writes each one back next
// cycle, aged if due; an extract scans all, then writes those behind the winner one lower.
// Reset clears the count and the tick counter; entry memory contents are not cleared.
// The result register is shown for one cycle; the receiver cannot stall it.
module aging_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = apq_pkg::DefaultDepth,
  localparam int unsigned AW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [apq_pkg::OpW-1:0]       operation_i,
  input  logic [apq_pkg::ClsW-1:0]      request_class_i,
  input  logic [apq_pkg::IdW-1:0]       request_id_i,
  output logic                          done_o,
  output logic [apq_pkg::StatusW-1:0]   status_o,
  output logic [apq_pkg::IdW-1:0]       granted_id_o,
  output logic [CW-1:0]                 occupancy_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apq_pkg::CfgAddrW-1:0]  paddr,
  input  logic [apq_pkg::CfgDataW-1:0]  pwdata,
  output logic [apq_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  apq_pkg::cfg_t cfg;

  apq_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Control state
  apq_pkg::state_e           state_q, state_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [apq_pkg::TimeW-1:0] now_q, now_d;
  logic [CW-1:0]             iss_q, iss_d;
  logic                      rvalid_q, rvalid_d;
  logic                      done_q, done_d;

  // Payload
  logic [AW-1:0]             ridx_q, ridx_d;
  logic [AW-1:0]             best_idx_q, best_idx_d;
  logic [apq_pkg::PrioW-1:0] best_prio_q, best_prio_d;
  logic [apq_pkg::IdW-1:0]   best_id_q, best_id_d;
  apq_pkg::status_e          status_q, status_d;
  logic [apq_pkg::IdW-1:0]   granted_q, granted_d;
  logic [CW-1:0]             occ_q, occ_d;

  // Entry memory
  apq_pkg::entry_t           mem_q [QUEUE_DEPTH];
  apq_pkg::entry_t           rdata_q;
  apq_pkg::entry_t           wdata;
  logic                      mem_we, mem_re;
  logic [AW-1:0]             waddr, raddr;

  logic                      accept, issue_en, scan_last, take;
  logic                      is_insert, is_extract, pipe_empty;
  logic [apq_pkg::TimeW-1:0] waited;
  logic                      aged;
  logic [apq_pkg::PrioW:0]   prio_sum;
  logic [apq_pkg::PrioW-1:0] aged_prio;

  assign accept     = start & ~busy;
  assign busy       = (state_q != apq_pkg::ST_IDLE);
  assign is_insert  = (operation_i == apq_pkg::OP_INSERT);
  assign is_extract = (operation_i == apq_pkg::OP_EXTRACT);
  assign issue_en   = busy && (iss_q < cnt_q);
  assign pipe_empty = !issue_en && !rvalid_q;
  assign scan_last  = rvalid_q && (CW'(ridx_q) == (cnt_q - CW'(1)));

  // Best so far, counting the item now returning from memory; earliest wins ties.
  assign take = (ridx_q == '0) || (rdata_q.prio > best_prio_q);

  // Aging of the entry returning from memory
  assign waited    = now_q - rdata_q.arrival;
  assign aged      = waited > {{(apq_pkg::TimeW - apq_pkg::PrioW){1'b0}}, cfg.aging_thresh};
  assign prio_sum  = {1'b0, rdata_q.prio} + {1'b0, cfg.aging_step};
  assign aged_prio = prio_sum[apq_pkg::PrioW] ? apq_pkg::PrioMax
                                              : prio_sum[apq_pkg::PrioW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      apq_pkg::ST_IDLE: begin
        if (accept && !is_insert && (cnt_q != '0)) begin
          state_d = is_extract ? apq_pkg::ST_SCAN : apq_pkg::ST_AGE;
        end
      end
      apq_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = apq_pkg::ST_SHIFT;
        end
      end
      apq_pkg::ST_SHIFT,
      apq_pkg::ST_AGE: begin
        if (pipe_empty) begin
          state_d = apq_pkg::ST_IDLE;
        end
      end
      default: state_d = apq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    cnt_d       = cnt_q;
    now_d       = now_q;
    iss_d       = issue_en ? (iss_q + CW'(1)) : iss_q;
    rvalid_d    = issue_en;
    ridx_d      = iss_q[AW-1:0];
    done_d      = 1'b0;
    best_idx_d  = best_idx_q;
    best_prio_d = best_prio_q;
    best_id_d   = best_id_q;
    status_d    = status_q;
    granted_d   = granted_q;
    occ_d       = occ_q;
    mem_re      = issue_en;
    raddr       = iss_q[AW-1:0];
    mem_we      = 1'b0;
    waddr       = ridx_q;
    wdata       = rdata_q;

    unique case (state_q)
      apq_pkg::ST_IDLE: begin
        if (accept) begin
          iss_d     = '0;
          granted_d = '0;
          occ_d     = cnt_q;
          if (is_insert) begin
            done_d = 1'b1;
            if (cnt_q < CW'(QUEUE_DEPTH)) begin
              mem_we       = 1'b1;
              waddr        = cnt_q[AW-1:0];
              wdata.id      = request_id_i;
              wdata.cls     = request_class_i;
              wdata.arrival = now_q;
              wdata.prio    = apq_pkg::class_prio(cfg, request_class_i);
              cnt_d        = cnt_q + CW'(1);
              occ_d        = cnt_q + CW'(1);
              status_d     = apq_pkg::STS_INSERTED;
            end else begin
              status_d = apq_pkg::STS_FULL;
            end
          end else if (is_extract) begin
            if (cnt_q == '0) begin
              done_d   = 1'b1;
              status_d = apq_pkg::STS_EMPTY;
            end
          end else begin
            now_d = now_q + apq_pkg::TimeW'(1);
            if (cnt_q == '0) begin
              done_d   = 1'b1;
              status_d = apq_pkg::STS_TICK_DONE;
            end
          end
        end
      end
      apq_pkg::ST_SCAN: begin
        if (rvalid_q && take) begin
          best_idx_d  = ridx_q;
          best_prio_d = rdata_q.prio;
          best_id_d   = rdata_q.id;
        end
        // Start the shift right behind the winner
        if (scan_last) begin
          iss_d = CW'(best_idx_d) + CW'(1);
        end
      end
      apq_pkg::ST_SHIFT: begin
        if (rvalid_q) begin
          mem_we = 1'b1;
          waddr  = ridx_q - AW'(1);
        end
        if (pipe_empty) begin
          done_d    = 1'b1;
          status_d  = apq_pkg::STS_EXTRACTED;
          granted_d = best_id_q;
          cnt_d     = cnt_q - CW'(1);
          occ_d     = cnt_q - CW'(1);
        end
      end
      apq_pkg::ST_AGE: begin
        if (rvalid_q) begin
          mem_we = 1'b1;
          if (aged) begin
            wdata.prio = aged_prio;
          end
        end
        if (pipe_empty) begin
          done_d   = 1'b1;
          status_d = apq_pkg::STS_TICK_DONE;
          occ_d    = cnt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= apq_pkg::ST_IDLE;
      cnt_q    <= '0;
      now_q    <= '0;
      iss_q    <= '0;
      rvalid_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      now_q    <= now_d;
      iss_q    <= iss_d;
      rvalid_q <= rvalid_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q      <= ridx_d;
    best_idx_q  <= best_idx_d;
    best_prio_q <= best_prio_d;
    best_id_q   <= best_id_d;
    status_q    <= status_d;
    granted_q   <= granted_d;
    occ_q       <= occ_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign granted_id_o = granted_q;
  assign occupancy_o  = occ_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (waddr != raddr))
    else $error("read and write hit the same entry in one cycle");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == apq_pkg::ST_SCAN) |-> !mem_we)
    else $error("entry memory written during extract scan");

  a_tick_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_insert && !is_extract) |=> (now_q == $past(now_q) + apq_pkg::TimeW'(1)))
    else $error("tick did not advance time by one");

endmodule

[tb/aging_priority_queue_unit_tb.sv]
// Self-checking bench for aging_priority_queue_unit: directed rows, then phased random traffic.
// A shadow queue predicts each untyped item's result; config goes through the APB port while idle.
// Depends on apq_pkg and the RTL of aging_priority_queue_unit.
module aging_priority_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apq_pkg::*;

  localparam int unsigned QDepth      = 16;
  localparam int unsigned OccW        = $clog2(QDepth + 1);
  localparam int unsigned PhaseItems  = 92;
  localparam int unsigned TailCycles  = 2 * QDepth + 8;

  // Codes outside the enums that the block must still handle.
  localparam logic [OpW-1:0]  OP_SPARE      = 2'd3;
  localparam logic [ClsW-1:0] CLS_SPARE     = 2'd3;
  localparam logic [2:0]      REG_SPARE_LO  = 3'd5;
  localparam logic [2:0]      REG_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     granted;
    logic [OccW-1:0]    occ;
  } queue_report_t;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [ClsW-1:0] cls;
    logic [IdW-1:0]  id;
    bit              typed;
    queue_report_t   rep;
  } stim_row_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                start           = 1'b0;
  logic                busy;
  logic [OpW-1:0]      operation_i     = '0;
  logic [ClsW-1:0]     request_class_i = '0;
  logic [IdW-1:0]      request_id_i    = '0;
  logic                done_o;
  logic [StatusW-1:0]  status_o;
  logic [IdW-1:0]      granted_id_o;
  logic [OccW-1:0]     occupancy_o;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [CfgAddrW-1:0] paddr           = '0;
  logic [CfgDataW-1:0] pwdata          = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Shadow copy of the queue and its registers.
  logic [IdW-1:0]   q_id      [QDepth];
  logic [ClsW-1:0]  q_cls     [QDepth];
  logic [TimeW-1:0] q_arrival [QDepth];
  logic [PrioW-1:0] q_prio    [QDepth];
  int unsigned      q_count;
  logic [TimeW-1:0] q_now;
  cfg_t             q_cfg;

  queue_report_t report_fifo[$];
  int unsigned   mismatch_count = 0;

  // Fill to full, overflow once, age everything, then pull the two oldest emergencies.
  stim_row_t directed_rows[26] = '{
    '{OP_EXTRACT, CLS_LANDING,   16'h0000, 1'b1, '{STS_EMPTY,     16'h0000, 5'd0}},
    '{OP_INSERT,  CLS_LANDING,   16'h0000, 1'b1, '{STS_INSERTED,  16'h0000, 5'd1}},
    '{OP_INSERT,  CLS_EMERGENCY, 16'hFFFF, 1'b1, '{STS_INSERTED,  16'h0000, 5'd2}},
    '{OP_INSERT,  CLS_TAKEOFF,   16'h1234, 1'b1, '{STS_INSERTED,  16'h0000, 5'd3}},
    '{OP_INSERT,  CLS_SPARE,     16'h8001, 1'b1, '{STS_INSERTED,  16'h0000, 5'd4}},
    '{OP_INSERT,  CLS_LANDING,   16'h7FFE, 1'b1, '{STS_INSERTED,  16'h0000, 5'd5}},
    '{OP_INSERT,  CLS_EMERGENCY, 16'h00FF, 1'b1, '{STS_INSERTED,  16'h0000, 5'd6}},
    '{OP_INSERT,  CLS_TAKEOFF,   16'hFF00, 1'b1, '{STS_INSERTED,  16'h0000, 5'd7}},
    '{OP_INSERT,  CLS_LANDING,   16'h5A5A, 1'b1, '{STS_INSERTED,  16'h0000, 5'd8}},
    '{OP_INSERT,  CLS_EMERGENCY, 16'hA5A5, 1'b1, '{STS_INSERTED,  16'h0000, 5'd9}},
    '{OP_INSERT,  CLS_SPARE,     16'h3C3C, 1'b1, '{STS_INSERTED,  16'h0000, 5'd10}},
    '{OP_INSERT,  CLS_TAKEOFF,   16'hC3C3, 1'b1, '{STS_INSERTED,  16'h0000, 5'd11}},
    '{OP_INSERT,  CLS_LANDING,   16'h0001, 1'b1, '{STS_INSERTED,  16'h0000, 5'd12}},
    '{OP_INSERT,  CLS_EMERGENCY, 16'h8000, 1'b1, '{STS_INSERTED,  16'h0000, 5'd13}},
    '{OP_INSERT,  CLS_TAKEOFF,   16'h0F0F, 1'b1, '{STS_INSERTED,  16'h0000, 5'd14}},
    '{OP_INSERT,  CLS_LANDING,   16'hF0F0, 1'b1, '{STS_INSERTED,  16'h0000, 5'd15}},
    '{OP_INSERT,  CLS_EMERGENCY, 16'h2468, 1'b1, '{STS_INSERTED,  16'h0000, 5'd16}},
    '{OP_INSERT,  CLS_LANDING,   16'h1357, 1'b1, '{STS_FULL,      16'h0000, 5'd16}},
    '{OP_TICK,    CLS_LANDING,   16'h0000, 1'b1, '{STS_TICK_DONE, 16'h0000, 5'd16}},
    '{OP_TICK,    CLS_SPARE,     16'hFFFF, 1'b1, '{STS_TICK_DONE, 16'h0000, 5'd16}},
    '{OP_TICK,    CLS_EMERGENCY, 16'h0000, 1'b1, '{STS_TICK_DONE, 16'h0000, 5'd16}},
    '{OP_TICK,    CLS_TAKEOFF,   16'h0000, 1'b1, '{STS_TICK_DONE, 16'h0000, 5'd16}},
    '{OP_TICK,    CLS_LANDING,   16'h0000, 1'b1, '{STS_TICK_DONE, 16'h0000, 5'd16}},
    '{OP_SPARE,   CLS_LANDING,   16'h4321, 1'b1, '{STS_TICK_DONE, 16'h0000, 5'd16}},
    '{OP_EXTRACT, CLS_TAKEOFF,   16'hBEEF, 1'b0, '0},
    '{OP_EXTRACT, CLS_SPARE,     16'h0000, 1'b0, '0}
  };

  aging_priority_queue_unit #(
    .QUEUE_DEPTH(QDepth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .request_class_i(request_class_i),
    .request_id_i   (request_id_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .granted_id_o   (granted_id_o),
    .occupancy_o    (occupancy_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Apply one item to the shadow queue and return the result it produces.
  function automatic queue_report_t shadow_queue_op(input logic [OpW-1:0]  op,
                                                     input logic [ClsW-1:0] cls,
                                                     input logic [IdW-1:0]  id);
    queue_report_t    rep;
    int unsigned      i;
    int unsigned      best;
    logic [TimeW-1:0] waited;
    logic [PrioW:0]   raised;
    rep = '0;
    if (op == OP_INSERT) begin
      if (q_count >= QDepth) begin
        rep.status = STS_FULL;
      end else begin
        q_id[q_count]      = id;
        q_cls[q_count]     = cls;
        q_arrival[q_count] = q_now;
        case (cls)
          CLS_LANDING:   q_prio[q_count] = q_cfg.landing_prio;
          CLS_EMERGENCY: q_prio[q_count] = q_cfg.emergency_prio;
          default:       q_prio[q_count] = q_cfg.takeoff_prio;
        endcase
        q_count++;
        rep.status = STS_INSERTED;
      end
    end else if (op == OP_EXTRACT) begin
      if (q_count == 0) begin
        rep.status = STS_EMPTY;
      end else begin
        best = 0;
        // strict compare keeps the earliest arrival on a tie
        for (i = 1; i < q_count; i++) begin
          if (q_prio[i] > q_prio[best]) best = i;
        end
        rep.granted = q_id[best];
        for (i = best; i + 1 < q_count; i++) begin
          q_id[i]      = q_id[i+1];
          q_cls[i]     = q_cls[i+1];
          q_arrival[i] = q_arrival[i+1];
          q_prio[i]    = q_prio[i+1];
        end
        q_count--;
        rep.status = STS_EXTRACTED;
      end
    end else begin
      q_now = q_now + 1'b1;
      for (i = 0; i < q_count; i++) begin
        waited = q_now - q_arrival[i];
        if (waited > {16'h0000, q_cfg.aging_thresh}) begin
          raised    = {1'b0, q_prio[i]} + {1'b0, q_cfg.aging_step};
          q_prio[i] = raised[PrioW] ? {PrioW{1'b1}} : raised[PrioW-1:0];
        end
      end
      rep.status = STS_TICK_DONE;
    end
    rep.occ = OccW'(q_count);
    return rep;
  endfunction

  // Present an item, hold it until accepted, queue up its predicted result.
  task automatic send_item(input logic [OpW-1:0] op, input logic [ClsW-1:0] cls,
                           input logic [IdW-1:0] id, input bit typed,
                           input queue_report_t typed_rep);
    queue_report_t rep;
    start           <= 1'b1;
    operation_i     <= op;
    request_class_i <= cls;
    request_id_i    <= id;
    do @(posedge clk_i); while (busy);
    rep = shadow_queue_op(op, cls, id);
    report_fifo.push_back(typed ? typed_rep : rep);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start           <= 1'b0;
    operation_i     <= OpW'($urandom());
    request_class_i <= ClsW'($urandom());
    request_id_i    <= IdW'($urandom());
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (report_fifo.size() != 0 || busy);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [PrioW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_EMERGENCY_PRIO: q_cfg.emergency_prio = value;
      REG_LANDING_PRIO:   q_cfg.landing_prio   = value;
      REG_TAKEOFF_PRIO:   q_cfg.takeoff_prio   = value;
      REG_AGING_THRESH:   q_cfg.aging_thresh   = value;
      REG_AGING_STEP:     q_cfg.aging_step     = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic read_reg(input logic [2:0] idx, output logic [PrioW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value   = prdata[PrioW-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_registers();
    logic [PrioW-1:0] got;
    read_reg(REG_EMERGENCY_PRIO, got);
    if (got !== q_cfg.emergency_prio) note_mismatch($sformatf("emergency reg %h", got));
    read_reg(REG_LANDING_PRIO, got);
    if (got !== q_cfg.landing_prio) note_mismatch($sformatf("landing reg %h", got));
    read_reg(REG_TAKEOFF_PRIO, got);
    if (got !== q_cfg.takeoff_prio) note_mismatch($sformatf("takeoff reg %h", got));
    read_reg(REG_AGING_THRESH, got);
    if (got !== q_cfg.aging_thresh) note_mismatch($sformatf("threshold reg %h", got));
    read_reg(REG_AGING_STEP, got);
    if (got !== q_cfg.aging_step) note_mismatch($sformatf("step reg %h", got));
  endtask

  // Reprogram while idle, then stream a mix of inserts, extracts and ticks.
  task automatic run_phase(input cfg_t cfg, input int unsigned ins_pct,
                           input int unsigned ext_pct, input bit gaps);
    int unsigned     k;
    int unsigned     r;
    logic [OpW-1:0]  op;
    drain_results();
    write_reg(REG_EMERGENCY_PRIO, cfg.emergency_prio);
    write_reg(REG_LANDING_PRIO,   cfg.landing_prio);
    write_reg(REG_TAKEOFF_PRIO,   cfg.takeoff_prio);
    write_reg(REG_AGING_THRESH,   cfg.aging_thresh);
    write_reg(REG_AGING_STEP,     cfg.aging_step);
    write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom()));
    check_registers();
    for (k = 0; k < PhaseItems; k++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct)                op = OP_INSERT;
      else if (r < ins_pct + ext_pct) op = OP_EXTRACT;
      else if ($urandom_range(0, 4) == 0) op = OP_SPARE;
      else                            op = OP_TICK;
      send_item(op, ClsW'($urandom_range(0, 3)), IdW'($urandom()), 1'b0, '0);
      // leave the first stretch of every 32 items back to back
      if (gaps && (k % 32) >= 10 && $urandom_range(0, 99) < 35)
        pause_sender($urandom_range(1, 6));
    end
  endtask

  always @(posedge clk_i) begin : result_check
    queue_report_t want;
    if (rst_ni && done_o) begin
      if (report_fifo.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d id %h occ %0d",
                                status_o, granted_id_o, occupancy_o));
      end else begin
        want = report_fifo.pop_front();
        if (status_o !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        if (granted_id_o !== want.granted)
          note_mismatch($sformatf("granted_id %h, want %h", granted_id_o, want.granted));
        if (occupancy_o !== want.occ)
          note_mismatch($sformatf("occupancy %0d, want %0d", occupancy_o, want.occ));
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    cfg_t cfg;
    int unsigned p;
    q_count = 0;
    q_now   = '0;
    q_cfg   = '{16'd100, 16'd50, 16'd10, 16'd5, 16'd5};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_registers();

    foreach (directed_rows[r])
      send_item(directed_rows[r].op, directed_rows[r].cls, directed_rows[r].id,
                directed_rows[r].typed, directed_rows[r].rep);

    // extremes first: saturating aging, all-zero ties, aging disabled
    run_phase('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 55, 30, 1'b1);
    run_phase('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 40, 45, 1'b1);
    run_phase('{16'd1, 16'd2, 16'd3, 16'hFFFF, 16'd1}, 65, 25, 1'b1);
    for (p = 0; p < 3; p++) begin
      cfg.emergency_prio = 16'($urandom());
      cfg.landing_prio   = 16'($urandom());
      cfg.takeoff_prio   = 16'($urandom());
      cfg.aging_thresh   = 16'($urandom_range(0, 6));
      cfg.aging_step     = (p == 1) ? 16'($urandom()) : 16'($urandom_range(0, 300));
      // final phase runs without sender gaps
      run_phase(cfg, (p == 1) ? 45 : 50, (p == 1) ? 40 : 35, p != 2);
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && report_fifo.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
